// ----- design/awra_pkg.sv -----
// shared types and codes for the aligned window range allocator
// no dependencies; imported by awra_table and the core top level
`default_nettype none

package awra_pkg;

   // command codes
   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_FREE   = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BAD     = 3'd1;
   localparam logic [2:0] ST_NOSPACE = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_NOOWNER = 3'd4;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_BASE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  owner;
      logic [63:0] range_size;
      logic [5:0]  align_log2;
      logic [63:0] fixed_base;
   } awra_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] granted_base;
   } awra_rsp_type;

   // one stored range, inclusive bounds
   typedef struct packed {
      logic [63:0] start_addr;
      logic [63:0] last_addr;
      logic [3:0]  owner;
   } awra_entry_type;

endpackage

`default_nettype wire

// ----- design/awra_table.sv -----
// range table: valid flops plus one entry memory with a registered read port
// depends on awra_pkg for the entry struct
`default_nettype none

module awra_table import awra_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output logic                             rd_valid,
   output awra_entry_type                   rd_entry,
   input  logic                             wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  awra_entry_type                   wr_entry,
   input  logic                             clr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] clr_addr
);

   awra_entry_type             entry_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]   valid_ff;
   logic                       rd_valid_ff;
   awra_entry_type             rd_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (clr_en) begin
            valid_ff[clr_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= entry_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_valid = rd_valid_ff;
   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

// ----- design/aligned_window_range_allocator_core.sv -----
// top level of the aligned window range allocator: sequencer, shared adder, csr
// depends on awra_pkg and awra_table
`default_nettype none

// usage
//  - command channel: a beat on req_data is taken when start is high and busy
//    is low; busy stays high until the result has been produced
//  - result channel: exactly one beat per command, rsp_data valid for the
//    single cycle rsp_valid is high; the receiver cannot stall it
//  - csr channel: csr_index 0 is window_base, 1 is window_limit; csr_ready is
//    always high, write only while busy is low
//  - sequencing (N = TABLE_ENTRIES): the sequencer walks the table one entry per
//    cycle through the table's single read port
//      free   : one full scan of the table, then the result beat
//      insert : a lowest-free scan up to the first free entry, then the store
//      alloc  : the free scan, then one full scan per probe of the
//               candidate, then the store and the result beat; at most
//               N probes since each jump leaves one more stored range behind
//    a rejected request answers from the check state, with no table scan
//  - reset clears the table valid bits, the sequencer and the window registers
//    (base 0, limit all ones); entry contents are left as they are
`default_nettype none

module aligned_window_range_allocator_core import awra_pkg::*; #(
   parameter int TABLE_ENTRIES = 64,
   parameter int OWNER_COUNT   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  awra_req_type           req_data,
   output logic                   rsp_valid,
   output awra_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_wdata
);

   localparam int IDXW = $clog2(TABLE_ENTRIES);
   localparam int CNTW = $clog2(TABLE_ENTRIES + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SLOT  = 3'd2;
   localparam logic [2:0] S_ALIGN = 3'd3;
   localparam logic [2:0] S_END   = 3'd4;
   localparam logic [2:0] S_OVL   = 3'd5;
   localparam logic [2:0] S_STORE = 3'd6;
   localparam logic [2:0] S_FREE  = 3'd7;

   logic [2:0]      state_ff, state_in;
   awra_req_type    req_ff, req_in;
   logic [63:0]     size_m1_ff, size_m1_in;
   logic [IDXW-1:0] slot_ff, slot_in;
   logic [63:0]     cand_ff, cand_in;
   logic [63:0]     lo_ff, lo_in;
   logic [63:0]     hi_ff, hi_in;
   logic            hit_ff, hit_in;
   logic [63:0]     best_ff, best_in;
   logic            any_ff, any_in;
   logic [CNTW-1:0] issue_ff, issue_in;
   logic            pend_ff, pend_in;
   logic [IDXW-1:0] data_idx_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   awra_rsp_type    rsp_data_ff, rsp_data_in;
   logic [63:0]     window_base_ff;
   logic [63:0]     window_limit_ff;

   // shared 65-bit adder, operands picked by state
   logic [63:0]     add_a, add_b;
   logic [64:0]     add_sum;

   logic [63:0]     align_mask;
   logic            size_zero;
   logic            owner_bad;
   logic            scan_active;
   logic            issue_more;
   logic            scan_done;
   logic            tbl_wr_en;
   logic            tbl_clr_en;
   logic            tbl_rd_valid;
   awra_entry_type  tbl_rd_entry;
   awra_entry_type  tbl_wr_entry;

   assign add_sum    = {1'b0, add_a} + {1'b0, add_b};
   assign align_mask = ~({64{1'b1}} << req_ff.align_log2);
   assign size_zero  = (req_ff.range_size == 64'd0);
   assign owner_bad  = ({28'd0, req_ff.owner} >= 32'(OWNER_COUNT));

   // table walk: one read issued per cycle, data comes back in the next cycle
   assign scan_active = (state_ff == S_SLOT) || (state_ff == S_OVL) || (state_ff == S_FREE);
   assign issue_more  = scan_active && (issue_ff != CNTW'(TABLE_ENTRIES));
   assign scan_done   = scan_active && !issue_more && !pend_ff;
   assign issue_in    = issue_more ? issue_ff + CNTW'(1) :
                        (scan_active ? issue_ff : '0);
   assign pend_in     = issue_more;

   assign tbl_wr_entry = '{start_addr: lo_ff, last_addr: hi_ff, owner: req_ff.owner};

   awra_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (issue_ff[IDXW-1:0]),
      .rd_valid (tbl_rd_valid),
      .rd_entry (tbl_rd_entry),
      .wr_en    (tbl_wr_en),
      .wr_addr  (slot_ff),
      .wr_entry (tbl_wr_entry),
      .clr_en   (tbl_clr_en),
      .clr_addr (data_idx_ff)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      size_m1_in   = size_m1_ff;
      slot_in      = slot_ff;
      cand_in      = cand_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      hit_in       = hit_ff;
      best_in      = best_ff;
      any_in       = any_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      tbl_wr_en    = 1'b0;
      tbl_clr_en   = 1'b0;
      add_a        = 64'd0;
      add_b        = 64'd0;

      unique case (state_ff)
         S_IDLE: begin
            // size minus one through the adder
            add_a = req_data.range_size;
            add_b = {64{1'b1}};
            if (start) begin
               req_in     = req_data;
               size_m1_in = add_sum[63:0];
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            // insert wrap check: fixed base plus size minus one
            add_a = req_ff.fixed_base;
            add_b = size_m1_ff;
            rsp_data_in = '{status: ST_BAD, granted_base: 64'd0};
            if (owner_bad) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               unique case (req_ff.command)
                  CMD_FREE: begin
                     any_in   = 1'b0;
                     state_in = S_FREE;
                  end
                  CMD_INSERT: begin
                     if (size_zero || ((req_ff.fixed_base & align_mask) != 64'd0) ||
                         add_sum[64]) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_IDLE;
                     end else begin
                        lo_in    = req_ff.fixed_base;
                        hi_in    = add_sum[63:0];
                        state_in = S_SLOT;
                     end
                  end
                  CMD_ALLOC: begin
                     if (size_zero) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_IDLE;
                     end else begin
                        state_in = S_SLOT;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               endcase
            end
         end
         S_SLOT: begin
            // lowest free entry, in index order
            if (pend_ff && !tbl_rd_valid) begin
               slot_in = data_idx_ff;
               if (req_ff.command == CMD_INSERT) begin
                  state_in = S_STORE;
               end else begin
                  cand_in  = window_base_ff;
                  state_in = S_ALIGN;
               end
            end else if (scan_done) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: ST_FULL, granted_base: 64'd0};
               state_in     = S_IDLE;
            end
         end
         S_ALIGN: begin
            // round the candidate up; carry out means it wrapped
            add_a = cand_ff;
            add_b = align_mask;
            if (add_sum[64]) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: ST_NOSPACE, granted_base: 64'd0};
               state_in     = S_IDLE;
            end else begin
               lo_in    = add_sum[63:0] & ~align_mask;
               state_in = S_END;
            end
         end
         S_END: begin
            add_a = lo_ff;
            add_b = size_m1_ff;
            if (add_sum[64] || (add_sum[63:0] > window_limit_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: ST_NOSPACE, granted_base: 64'd0};
               state_in     = S_IDLE;
            end else begin
               hi_in    = add_sum[63:0];
               hit_in   = 1'b0;
               best_in  = 64'd0;
               state_in = S_OVL;
            end
         end
         S_OVL: begin
            // track the greatest last address among overlapping ranges
            add_a = best_ff;
            add_b = 64'd1;
            if (pend_ff && tbl_rd_valid && (lo_ff <= tbl_rd_entry.last_addr) &&
                (tbl_rd_entry.start_addr <= hi_ff)) begin
               hit_in = 1'b1;
               if (!hit_ff || (tbl_rd_entry.last_addr > best_ff)) begin
                  best_in = tbl_rd_entry.last_addr;
               end
            end
            if (scan_done) begin
               if (!hit_ff) begin
                  state_in = S_STORE;
               end else if (&best_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{status: ST_NOSPACE, granted_base: 64'd0};
                  state_in     = S_IDLE;
               end else begin
                  // jump past the conflict and probe again
                  cand_in  = add_sum[63:0];
                  state_in = S_ALIGN;
               end
            end
         end
         S_STORE: begin
            tbl_wr_en    = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{status: ST_OK, granted_base: lo_ff};
            state_in     = S_IDLE;
         end
         S_FREE: begin
            if (pend_ff && tbl_rd_valid && (tbl_rd_entry.owner == req_ff.owner)) begin
               tbl_clr_en = 1'b1;
               any_in     = 1'b1;
            end
            if (scan_done) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: (any_ff ? ST_OK : ST_NOOWNER),
                                granted_base: 64'd0};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and csr
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         issue_ff        <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         window_base_ff  <= 64'd0;
         window_limit_ff <= {64{1'b1}};
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_WINDOW_BASE:  window_base_ff  <= csr_wdata;
               REG_WINDOW_LIMIT: window_limit_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      size_m1_ff  <= size_m1_in;
      slot_ff     <= slot_in;
      cand_ff     <= cand_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      hit_ff      <= hit_in;
      best_ff     <= best_in;
      any_ff      <= any_in;
      data_idx_ff <= issue_ff[IDXW-1:0];
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result only appears once the sequencer has gone back to idle
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result beat while sequencer busy");

   // a command always takes the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not start the sequencer");

   // one beat per command, never two in a row
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back to back result beats");

   // a nonzero base is only granted with an ok status
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.granted_base != 64'd0)) |->
      (rsp_data_ff.status == ST_OK))
      else $error("granted base with failing status");

   // the rounded candidate honors the requested alignment
   a_lo_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_END) |-> ((lo_ff & align_mask) == 64'd0))
      else $error("candidate not aligned");

endmodule

`default_nettype wire

// ----- tb/awra_checker.sv -----
// checker for the aligned window range allocator: keeps a private copy of the
// range table and window, predicts each result beat and compares it on arrival
// depends on awra_pkg
module awra_checker import awra_pkg::*; #(
   parameter int TABLE_ENTRIES = 64,
   parameter int OWNER_COUNT   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  awra_req_type           req_data,
   input  logic                   rsp_valid,
   input  awra_rsp_type           rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_wdata,
   output int                     bad_grants,
   output int                     grants_in_flight
);

   localparam logic [63:0] TOP_ADDR = '1;

   logic [63:0]  win_base;
   logic [63:0]  win_limit;
   logic         range_used  [TABLE_ENTRIES];
   logic [63:0]  range_first [TABLE_ENTRIES];
   logic [63:0]  range_last  [TABLE_ENTRIES];
   logic [3:0]   range_owner [TABLE_ENTRIES];
   awra_rsp_type pending_grants [$];
   int           fail_total = 0;

   function automatic int first_free_slot();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (!range_used[i]) return i;
      end
      return TABLE_ENTRIES;
   endfunction

   function automatic void claim(int slot, logic [63:0] lo, logic [63:0] hi,
                                 logic [3:0] who);
      range_used[slot]  = 1'b1;
      range_first[slot] = lo;
      range_last[slot]  = hi;
      range_owner[slot] = who;
   endfunction

   // outcome of one command beat, updating the private table as the block would
   function automatic awra_rsp_type predict_grant(awra_req_type r);
      awra_rsp_type res;
      logic [63:0]  mask;
      logic [63:0]  span;
      logic [63:0]  cand;
      logic [63:0]  lo;
      logic [63:0]  hi;
      logic [63:0]  top;
      int           slot;
      bit           hit;
      bit           any;
      bit           done;
      mask = (64'd1 << r.align_log2) - 64'd1;
      span = r.range_size - 64'd1;
      res.status = ST_OK;
      res.granted_base = '0;
      if (r.command > CMD_FREE || r.owner >= OWNER_COUNT) begin
         res.status = ST_BAD;
      end else if (r.command == CMD_FREE) begin
         any = 1'b0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (range_used[i] && range_owner[i] == r.owner) begin
               range_used[i] = 1'b0;
               any = 1'b1;
            end
         end
         if (!any) res.status = ST_NOOWNER;
      end else if (r.range_size == '0) begin
         res.status = ST_BAD;
      end else if (r.command == CMD_INSERT &&
                   ((r.fixed_base & mask) != '0 || r.fixed_base > TOP_ADDR - span)) begin
         res.status = ST_BAD;
      end else begin
         slot = first_free_slot();
         if (slot >= TABLE_ENTRIES) begin
            res.status = ST_FULL;
         end else if (r.command == CMD_INSERT) begin
            claim(slot, r.fixed_base, r.fixed_base + span, r.owner);
            res.granted_base = r.fixed_base;
         end else begin
            cand = win_base;
            done = 1'b0;
            while (!done) begin
               if (cand > TOP_ADDR - mask) begin
                  res.status = ST_NOSPACE;
                  done = 1'b1;
               end else begin
                  lo = (cand + mask) & ~mask;
                  hi = lo + span;
                  if (lo > TOP_ADDR - span || hi > win_limit) begin
                     res.status = ST_NOSPACE;
                     done = 1'b1;
                  end else begin
                     hit = 1'b0;
                     top = '0;
                     for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (range_used[i] && lo <= range_last[i] && range_first[i] <= hi) begin
                           if (!hit || range_last[i] > top) top = range_last[i];
                           hit = 1'b1;
                        end
                     end
                     if (!hit) begin
                        claim(slot, lo, hi, r.owner);
                        res.granted_base = lo;
                        done = 1'b1;
                     end else if (top == TOP_ADDR) begin
                        res.status = ST_NOSPACE;
                        done = 1'b1;
                     end else begin
                        cand = top + 64'd1;
                     end
                  end
               end
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      awra_rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) range_used[i] = 1'b0;
         win_base  = '0;
         win_limit = TOP_ADDR;
         pending_grants.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_WINDOW_BASE) win_base = csr_wdata;
            else if (csr_index == REG_WINDOW_LIMIT) win_limit = csr_wdata;
         end
         if (rsp_valid) begin
            if (pending_grants.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: result beat with none expected: status %0d base %h",
                           $realtime, rsp_data.status, rsp_data.granted_base);
            end else begin
               want = pending_grants.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.granted_base !== want.granted_base) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display("%0t: grant mismatch: expected status %0d base %h, got status %0d base %h",
                              $realtime, want.status, want.granted_base,
                              rsp_data.status, rsp_data.granted_base);
               end
            end
         end
         if (start && !busy) pending_grants.push_back(predict_grant(req_data));
      end
      bad_grants       <= fail_total;
      grants_in_flight <= pending_grants.size();
   end

endmodule

// ----- tb/tb_aligned_window_range_allocator_core.sv -----
// stimulus and verdict for aligned_window_range_allocator_core: directed corner
// beats, then random fill and churn phases under several windows
// depends on awra_pkg, the core and awra_checker
module tb_aligned_window_range_allocator_core;
   import awra_pkg::*;

   localparam int          TABLE_ENTRIES = 64;
   localparam int          OWNER_COUNT   = 16;
   // watchdog limit: room for about 145 beats of the slowest alloc, taken several times
   localparam int          LIMIT_CYCLES  = 3_000_000;
   localparam int          FILL_BEATS    = 70;
   localparam int          CHURN_BEATS   = 25;
   // the one command code the block has no use for
   localparam logic [1:0]  CMD_UNUSED    = 2'd3;
   localparam logic [63:0] TOP_ADDR      = '1;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   awra_req_type           req_data  = '0;
   logic                   csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]            csr_wdata = '0;
   logic                   busy;
   logic                   rsp_valid;
   awra_rsp_type           rsp_data;
   logic                   csr_ready;
   int                     bad_grants;
   int                     grants_in_flight;
   int                     cycle_count = 0;
   // base of the current window, used to aim insert addresses near it
   logic [63:0]            cur_base = '0;
   // set during the fill phase: the sender never idles there
   bit                     steady = 1'b0;

   always #5 clock = ~clock;

   aligned_window_range_allocator_core #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .OWNER_COUNT  (OWNER_COUNT)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   awra_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .OWNER_COUNT  (OWNER_COUNT)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .bad_grants      (bad_grants),
      .grants_in_flight(grants_in_flight)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic awra_req_type mk_beat(logic [1:0] cmd, logic [3:0] who,
                                            logic [63:0] size, logic [5:0] alog,
                                            logic [63:0] fixed);
      awra_req_type b;
      b.command    = cmd;
      b.owner      = who;
      b.range_size = size;
      b.align_log2 = alog;
      b.fixed_base = fixed;
      return b;
   endfunction

   // mostly small sizes, with zero, powers of two, full-width and near-top ones
   function automatic logic [63:0] rand_size();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick <= 12) return 64'($urandom_range(1, 'h400));
      if (pick <= 14) return 64'd1 << $urandom_range(0, 63);
      if (pick <= 17) return {$urandom, $urandom};
      return TOP_ADDR - 64'($urandom_range(0, 'hff));
   endfunction

   function automatic logic [5:0] rand_alog();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 6) return 6'($urandom_range(0, 8));
      if (pick <= 8) return 6'($urandom_range(0, 20));
      return 6'($urandom_range(0, 63));
   endfunction

   // insert address: aligned near the window, or random, or close to the top
   function automatic logic [63:0] rand_fixed(logic [5:0] alog, bit in_window);
      logic [63:0] mask;
      int          pick;
      mask = (64'd1 << alog) - 64'd1;
      pick = in_window ? 0 : $urandom_range(0, 19);
      if (pick < 14) return (cur_base + 64'($urandom_range(0, 'hffff))) & ~mask;
      if (pick < 17) return {$urandom, $urandom};
      return (TOP_ADDR - 64'($urandom_range(0, 'hffff))) & ~mask;
   endfunction

   // filling: allocs and well-formed inserts only, so the table runs full
   function automatic awra_req_type rand_beat(bit filling);
      awra_req_type b;
      int           pick;
      pick = $urandom_range(0, 99);
      b.owner = 4'($urandom_range(0, 15));
      if (filling) begin
         b.command    = (pick < 85) ? CMD_ALLOC : CMD_INSERT;
         b.range_size = 64'($urandom_range(1, 'h400));
         b.align_log2 = 6'($urandom_range(0, 8));
      end else begin
         if (pick < 45) b.command = CMD_ALLOC;
         else if (pick < 70) b.command = CMD_INSERT;
         else if (pick < 95) b.command = CMD_FREE;
         else b.command = CMD_UNUSED;
         b.range_size = rand_size();
         b.align_log2 = rand_alog();
      end
      // fixed_base is don't-care for alloc and free, so let it be noise there
      if (b.command == CMD_INSERT) b.fixed_base = rand_fixed(b.align_log2, filling);
      else b.fixed_base = {$urandom, $urandom};
      return b;
   endfunction

   // both window registers in one burst, valid held high across the two beats
   task automatic set_window(logic [63:0] base, logic [63:0] limit);
      csr_valid <= 1'b1;
      csr_index <= REG_WINDOW_BASE;
      csr_wdata <= base;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= REG_WINDOW_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_base = base;
   endtask

   // random sender gap after an accepted beat; long enough to land both while
   // the block is still scanning and after it has gone idle
   task automatic rest_sender();
      if (!steady && $urandom_range(0, 99) < 25) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 100)) @(posedge clock);
      end
   endtask

   // hold the beat until the block takes it; start stays high into the next
   // beat unless the sender rests
   task automatic issue(awra_req_type b);
      req_data <= b;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      rest_sender();
   endtask

   // lower start and wait until every expected result beat is back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (grants_in_flight != 0 || busy) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [63:0] base;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // full-range window
      set_window('0, TOP_ADDR);
      issue(mk_beat(CMD_UNUSED, 4'd0, 64'h10, 6'd0, '0));         // unknown command
      issue(mk_beat(CMD_ALLOC, 4'd1, '0, 6'd0, '0));              // zero-size alloc
      issue(mk_beat(CMD_INSERT, 4'd1, '0, 6'd0, '0));             // zero-size insert
      issue(mk_beat(CMD_FREE, 4'd5, '0, 6'd0, '0));               // free of empty owner
      issue(mk_beat(CMD_ALLOC, 4'd0, 64'h100, 6'd8, '0));
      issue(mk_beat(CMD_ALLOC, 4'd1, 64'h1, 6'd0, TOP_ADDR));
      issue(mk_beat(CMD_ALLOC, 4'd2, 64'h10, 6'd4, '0));
      issue(mk_beat(CMD_INSERT, 4'd3, 64'h10, 6'd2, 64'h1003));   // misaligned insert
      issue(mk_beat(CMD_INSERT, 4'd3, 64'h1000, 6'd12, 64'h1000));
      issue(mk_beat(CMD_INSERT, 4'd4, 64'h10, 6'd4, 64'h1800));   // overlap is allowed
      issue(mk_beat(CMD_INSERT, 4'd15, 64'h20, 6'd4, TOP_ADDR - 64'hf)); // wraps
      issue(mk_beat(CMD_INSERT, 4'd15, 64'h10, 6'd4, TOP_ADDR - 64'hf));
      issue(mk_beat(CMD_INSERT, 4'd15, 64'h1, 6'd0, TOP_ADDR));
      // conflict ending at the very top address
      issue(mk_beat(CMD_ALLOC, 4'd9, TOP_ADDR, 6'd0, '0));
      // coarsest alignment: first lands at the half point, second wraps
      issue(mk_beat(CMD_ALLOC, 4'd8, 64'h10, 6'd63, '0));
      issue(mk_beat(CMD_ALLOC, 4'd8, 64'h10, 6'd63, '0));
      issue(mk_beat(CMD_FREE, 4'd15, '0, 6'd0, '0));
      issue(mk_beat(CMD_FREE, 4'd0, '0, 6'd0, TOP_ADDR));
      drain();

      // window starting just below the top of the address space
      set_window(TOP_ADDR - 64'hffe, TOP_ADDR);
      issue(mk_beat(CMD_ALLOC, 4'd6, 64'h10, 6'd12, '0));         // aligned candidate wraps
      issue(mk_beat(CMD_ALLOC, 4'd6, 64'h1000, 6'd0, '0));        // end wraps
      issue(mk_beat(CMD_ALLOC, 4'd6, 64'h10, 6'd0, '0));
      drain();

      // tight window that one range fills exactly
      set_window(64'h2000, 64'h2fff);
      issue(mk_beat(CMD_ALLOC, 4'd7, 64'h1000, 6'd0, '0));
      issue(mk_beat(CMD_ALLOC, 4'd7, 64'h1, 6'd0, '0));           // passes the limit
      drain();

      // fill phase: back-to-back beats, enough grants to hit table full
      set_window(64'h10000, 64'h1ffff);
      steady = 1'b1;
      repeat (FILL_BEATS) issue(rand_beat(1'b1));
      drain();
      steady = 1'b0;

      // churn over the whole address space
      set_window('0, TOP_ADDR);
      repeat (CHURN_BEATS) issue(rand_beat(1'b0));
      drain();

      // churn in a small random window
      base = 64'($urandom_range(0, 15)) << 16;
      set_window(base, base + 64'h7fff);
      repeat (CHURN_BEATS) issue(rand_beat(1'b0));
      drain();

      // tail: catch any stray result beat
      repeat (TABLE_ENTRIES + 8) @(posedge clock);
      if (bad_grants == 0 && grants_in_flight == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
